@@ rtl/rsenc_pkg.sv @@
// Shared types, constants and GF(2^8) arithmetic for the Reed-Solomon parity encoder.
package rsenc_pkg;

   localparam int BYTE_W = 8;
   localparam int DEGREE_W = 6;
   localparam int RESET_DEGREE = 10;
   localparam logic [BYTE_W-1:0] FIELD_POLY_LOW = 8'h1D;
   localparam logic [BYTE_W-1:0] ROOT_STEP = 8'h02;
   localparam logic [BYTE_W-1:0] ROOT_FIRST = 8'h01;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              msg_end;
   } rsenc_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] parity_byte;
      logic              parity_last;
   } rsenc_rsp_type;

   typedef struct packed {
      logic init;
      logic gen_step;
      logic absorb;
      logic load;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      GEN_INIT,
      GEN_BUILD,
      GEN_READY
   } gen_state_type;

   function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] acc;
      acc = '0;
      for (int k = BYTE_W - 1; k >= 0; k--) begin
         acc = {acc[BYTE_W-2:0], 1'b0} ^ (acc[BYTE_W-1] ? FIELD_POLY_LOW : '0);
         acc = acc ^ (b[k] ? a : '0);
      end
      return acc;
   endfunction

endpackage

@@ rtl/rsenc_cell.sv @@
// One cell of the encoder row: remainder, generator coefficient and parity output stage.
module rsenc_cell (
   input  logic                        clock,
   input  rsenc_pkg::cell_ctrl_type    ctrl,
   input  logic                        init_bit,
   input  logic [rsenc_pkg::BYTE_W-1:0] mul_op,
   input  logic [rsenc_pkg::BYTE_W-1:0] r_nb,
   input  logic [rsenc_pkg::BYTE_W-1:0] g_nb,
   input  logic [rsenc_pkg::BYTE_W-1:0] s_nb,
   output logic [rsenc_pkg::BYTE_W-1:0] r_q,
   output logic [rsenc_pkg::BYTE_W-1:0] g_q,
   output logic [rsenc_pkg::BYTE_W-1:0] s_q
);

   logic [rsenc_pkg::BYTE_W-1:0] r_ff, r_in;
   logic [rsenc_pkg::BYTE_W-1:0] g_ff, g_in;
   logic [rsenc_pkg::BYTE_W-1:0] s_ff, s_in;
   logic [rsenc_pkg::BYTE_W-1:0] prod;
   logic [rsenc_pkg::BYTE_W-1:0] r_sum;

   assign prod  = rsenc_pkg::gf_mul(g_ff, mul_op);
   assign r_sum = r_nb ^ prod;

   always_comb begin
      r_in = r_ff;
      g_in = g_ff;
      s_in = s_ff;
      if (ctrl.init) begin
         g_in = {{(rsenc_pkg::BYTE_W-1){1'b0}}, init_bit};
         r_in = '0;
      end
      if (ctrl.gen_step) begin
         g_in = prod ^ g_nb;
      end
      if (ctrl.absorb) begin
         r_in = ctrl.load ? '0 : r_sum;
      end
      if (ctrl.load) begin
         s_in = r_sum;
      end else if (ctrl.shift) begin
         s_in = s_nb;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      g_ff <= g_in;
      s_ff <= s_in;
   end

   assign r_q = r_ff;
   assign g_q = g_ff;
   assign s_q = s_ff;

endmodule

@@ rtl/reed_solomon_parity_encoder.sv @@
// Top level of the systematic Reed-Solomon parity encoder over GF(2^8), polynomial 0x11D.
//
// The encoder takes one message codeword per cycle into a row of identical cells, each
// holding one remainder byte and one generator coefficient and performing one GF(2^8)
// multiply per cycle. When the codeword marked as the end of the message is taken, the
// remainder is copied into the output row of the same cells and the division register is
// cleared, so the next message streams in at once. The parity bytes then leave at one
// item per cycle while rsp_ready is high, highest order first; a further end-of-message
// codeword waits until the previous parity run has drained. After reset and after every
// write of the degree, the generator polynomial is rebuilt in the same cells, during which
// no codeword is taken.
module reed_solomon_parity_encoder #(
   parameter int MAX_DEGREE = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rsenc_pkg::rsenc_req_type            req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rsenc_pkg::rsenc_rsp_type            rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rsenc_pkg::DEGREE_W-1:0]      csr_wdata
);

   localparam int DW = $clog2(MAX_DEGREE + 1);
   localparam int RESET_DEG_INT = (rsenc_pkg::RESET_DEGREE > MAX_DEGREE) ?
                                  MAX_DEGREE : rsenc_pkg::RESET_DEGREE;
   localparam logic [DW-1:0] RESET_DEG = DW'(RESET_DEG_INT);
   localparam logic [DW-1:0] MAX_DEG = DW'(MAX_DEGREE);

   rsenc_pkg::gen_state_type state_ff, state_in;
   logic [DW-1:0]            degree_ff, degree_in;
   logic [DW-1:0]            step_ff, step_in;
   logic [DW-1:0]            cnt_ff, cnt_in;
   logic [rsenc_pkg::BYTE_W-1:0] root_ff, root_in;
   rsenc_pkg::cell_ctrl_type ctrl;

   logic [rsenc_pkg::BYTE_W-1:0] r_chain [0:MAX_DEGREE];
   logic [rsenc_pkg::BYTE_W-1:0] g_chain [0:MAX_DEGREE];
   logic [rsenc_pkg::BYTE_W-1:0] s_chain [0:MAX_DEGREE];
   logic [MAX_DEGREE-1:0]        init_bits;
   logic [rsenc_pkg::BYTE_W-1:0] factor;
   logic [rsenc_pkg::BYTE_W-1:0] mul_op;

   logic req_fire;
   logic rsp_fire;
   logic csr_fire;
   logic par_free;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;
   assign rsp_fire  = rsp_valid & rsp_ready;
   assign par_free  = (cnt_ff == '0) | ((cnt_ff == DW'(1)) & rsp_ready);
   assign req_ready = (state_ff == rsenc_pkg::GEN_READY) & (~req_data.msg_end | par_free);
   assign req_fire  = req_valid & req_ready;

   assign factor = req_data.data_byte ^ r_chain[0];
   assign mul_op = (state_ff == rsenc_pkg::GEN_BUILD) ? root_ff : factor;

   assign r_chain[MAX_DEGREE] = '0;
   assign g_chain[MAX_DEGREE] = '0;
   assign s_chain[MAX_DEGREE] = '0;

   for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_cell
      assign init_bits[i] = (degree_ff == DW'(i + 1));
      rsenc_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .init_bit (init_bits[i]),
         .mul_op   (mul_op),
         .r_nb     (r_chain[i+1]),
         .g_nb     (g_chain[i+1]),
         .s_nb     (s_chain[i+1]),
         .r_q      (r_chain[i]),
         .g_q      (g_chain[i]),
         .s_q      (s_chain[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      if (csr_fire) begin
         state_in = rsenc_pkg::GEN_INIT;
      end else begin
         case (state_ff)
            rsenc_pkg::GEN_INIT: begin
               state_in = rsenc_pkg::GEN_BUILD;
            end
            rsenc_pkg::GEN_BUILD: begin
               if (step_ff == degree_ff - DW'(1)) begin
                  state_in = rsenc_pkg::GEN_READY;
               end
            end
            rsenc_pkg::GEN_READY: begin
               state_in = rsenc_pkg::GEN_READY;
            end
            default: begin
               state_in = rsenc_pkg::GEN_INIT;
            end
         endcase
      end
   end

   always_comb begin
      ctrl.init     = (state_ff == rsenc_pkg::GEN_INIT);
      ctrl.gen_step = (state_ff == rsenc_pkg::GEN_BUILD);
      ctrl.absorb   = req_fire;
      ctrl.load     = req_fire & req_data.msg_end;
      ctrl.shift    = rsp_fire;
      step_in       = step_ff;
      root_in       = root_ff;
      case (state_ff)
         rsenc_pkg::GEN_INIT: begin
            step_in = '0;
            root_in = rsenc_pkg::ROOT_FIRST;
         end
         rsenc_pkg::GEN_BUILD: begin
            step_in = step_ff + DW'(1);
            root_in = rsenc_pkg::gf_mul(root_ff, rsenc_pkg::ROOT_STEP);
         end
         default: begin
            step_in = step_ff;
         end
      endcase
   end

   always_comb begin
      degree_in = degree_ff;
      if (csr_fire) begin
         if (csr_wdata == '0) begin
            degree_in = DW'(1);
         end else if (int'(csr_wdata) > MAX_DEGREE) begin
            degree_in = MAX_DEG;
         end else begin
            degree_in = DW'(csr_wdata);
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (ctrl.load) begin
         cnt_in = degree_ff;
      end else if (rsp_fire) begin
         cnt_in = cnt_ff - DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rsenc_pkg::GEN_INIT;
         degree_ff <= RESET_DEG;
         cnt_ff    <= '0;
         step_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         degree_ff <= degree_in;
         cnt_ff    <= cnt_in;
         step_ff   <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      root_ff <= root_in;
   end

   assign rsp_valid            = (cnt_ff != '0);
   assign rsp_data.parity_byte = s_chain[0];
   assign rsp_data.parity_last = (cnt_ff == DW'(1));

endmodule

@@ rtl/rsenc_monitor.sv @@
// Port-level assertions for the Reed-Solomon parity encoder, bound to the top level.
module rsenc_monitor (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input rsenc_pkg::rsenc_req_type            req_data,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input rsenc_pkg::rsenc_rsp_type            rsp_data,
   input logic                                csr_valid,
   input logic                                csr_ready
);

   // A parity item that is not taken must hold until it is.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("parity item changed while stalled");

   // The generator is rebuilt after reset, so no codeword is taken straight away.
   a_busy_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_ready)
      else $error("codeword accepted during generator build after reset");

   // A degree write starts a rebuild, which blocks codewords.
   a_busy_after_csr: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready)
      else $error("codeword accepted during generator build after degree write");

   // The end of a message brings parity out on the next cycle.
   a_parity_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.msg_end |=> rsp_valid)
      else $error("no parity item after end of message");

endmodule

bind reed_solomon_parity_encoder rsenc_monitor u_rsenc_monitor (.*);
